FILE: design/lrfb_pkg.sv
// Shared constants, command codes and the queued command type of the LED ring frame buffer.
`timescale 1ns / 1ps
package lrfb_pkg;

  localparam int NUM_RINGS     = 4;
  localparam int LEDS_PER_RING = 64;
  localparam int MEM_DEPTH     = NUM_RINGS * LEDS_PER_RING;
  localparam int ADDR_W        = $clog2(MEM_DEPTH);

  localparam int OP_W       = 3;
  localparam int RING_W     = 2;
  localparam int POS_W      = 6;
  localparam int LEVEL_W    = 4;
  localparam int MAP_IDX_W  = 5;
  localparam int MAP_BYTE_W = 8;
  localparam int RING_CMP_W = 4;

  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = 1;
  localparam int FIFO_CNT_W = 2;

  localparam logic [OP_W-1:0] OP_SET_LED    = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_ALL    = 3'd1;
  localparam logic [OP_W-1:0] OP_FILL_RING  = 3'd2;
  localparam logic [OP_W-1:0] OP_MAP_BYTE   = 3'd3;
  localparam logic [OP_W-1:0] OP_RANGE_FILL = 3'd4;
  localparam logic [OP_W-1:0] OP_READ_LED   = 3'd5;

  localparam logic [1:0] CK_WRITE     = 2'd0;
  localparam logic [1:0] CK_READ      = 2'd1;
  localparam logic [1:0] CK_READ_ZERO = 2'd2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [ADDR_W-1:0]  addr;
    logic [ADDR_W-1:0]  last;
    logic               whole;
    logic [LEVEL_W-1:0] level_first;
    logic [LEVEL_W-1:0] level_rest;
  } cmd_t;

endpackage

FILE: design/lrfb_ram.sv
// Generic simple dual-port RAM with a registered read port.
`timescale 1ns / 1ps
module lrfb_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

FILE: design/lrfb_front.sv
// Front end: accepts command words and turns them into queued memory commands.
`timescale 1ns / 1ps
module lrfb_front import lrfb_pkg::*; (
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [RING_W-1:0]     in_ring,
  input  logic [POS_W-1:0]      in_position,
  input  logic [POS_W-1:0]      in_end_position,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [MAP_IDX_W-1:0]  in_map_index,
  input  logic [MAP_BYTE_W-1:0] in_map_byte,
  input  logic                  fifo_full,
  input  logic                  clear_busy,
  output logic                  fifo_push,
  output cmd_t                  fifo_cmd
);

  logic ring_ok;
  logic keep;

  assign ring_ok = RING_CMP_W'(in_ring) < RING_CMP_W'(NUM_RINGS);

  always_comb begin
    fifo_cmd             = '0;
    fifo_cmd.kind        = CK_WRITE;
    fifo_cmd.addr        = ADDR_W'({in_ring, in_position});
    fifo_cmd.last        = '0;
    fifo_cmd.whole       = 1'b0;
    fifo_cmd.level_first = in_level;
    fifo_cmd.level_rest  = in_level;
    keep                 = ring_ok;
    unique case (in_operation)
      OP_SET_LED: begin
        keep = ring_ok;
      end
      OP_SET_ALL: begin
        fifo_cmd.addr  = '0;
        fifo_cmd.last  = ADDR_W'(MEM_DEPTH - 1);
        fifo_cmd.whole = 1'b1;
        keep           = 1'b1;
      end
      OP_FILL_RING: begin
        fifo_cmd.addr = ADDR_W'({in_ring, POS_W'(0)});
        fifo_cmd.last = ADDR_W'(LEDS_PER_RING - 1);
      end
      OP_MAP_BYTE: begin
        fifo_cmd.addr        = ADDR_W'({in_ring, in_map_index, 1'b0});
        fifo_cmd.last        = ADDR_W'(1);
        fifo_cmd.level_first = in_map_byte[MAP_BYTE_W-1:LEVEL_W];
        fifo_cmd.level_rest  = in_map_byte[LEVEL_W-1:0];
      end
      OP_RANGE_FILL: begin
        fifo_cmd.last = ADDR_W'(POS_W'(in_end_position - in_position));
      end
      OP_READ_LED: begin
        fifo_cmd.kind = ring_ok ? CK_READ : CK_READ_ZERO;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign in_stall  = fifo_full | clear_busy;
  assign fifo_push = in_valid & ~in_stall & keep;

endmodule

FILE: design/lrfb_cmd_fifo.sv
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps
module lrfb_cmd_fifo import lrfb_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t pop_cmd,
  output logic empty
);

  cmd_t                  entry_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] count_r, count_nxt;

  assign full    = count_r == FIFO_CNT_W'(FIFO_DEPTH);
  assign empty   = count_r == '0;
  assign pop_cmd = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

FILE: design/lrfb_back.sv
// Back end: runs queued commands against the level memory and drives the result word.
`timescale 1ns / 1ps
module lrfb_back import lrfb_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fifo_empty,
  input  cmd_t               fifo_cmd,
  output logic               fifo_pop,
  output logic               clear_busy,
  output logic               ram_we,
  output logic [ADDR_W-1:0]  ram_waddr,
  output logic [LEVEL_W-1:0] ram_wdata,
  output logic               ram_re,
  output logic [ADDR_W-1:0]  ram_raddr,
  input  logic [LEVEL_W-1:0] ram_rdata,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_read_level
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_WRITE = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;

  logic [1:0]         state_r, state_nxt;
  logic               clear_r, clear_nxt;
  logic [ADDR_W-1:0]  addr_r, addr_nxt;
  logic [ADDR_W-1:0]  count_r, count_nxt;
  logic               whole_r, whole_nxt;
  logic [LEVEL_W-1:0] level_cur_r, level_cur_nxt;
  logic [LEVEL_W-1:0] level_rest_r, level_rest_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic               out_free;
  logic [ADDR_W-1:0]  addr_ring_inc;

  assign out_free      = ~out_valid_r | ~out_stall;
  assign addr_ring_inc = (addr_r & ~ADDR_W'(LEDS_PER_RING - 1))
                       | ADDR_W'(POS_W'(addr_r[POS_W-1:0] + POS_W'(1)));

  always_comb begin
    state_nxt      = state_r;
    clear_nxt      = clear_r;
    addr_nxt       = addr_r;
    count_nxt      = count_r;
    whole_nxt      = whole_r;
    level_cur_nxt  = level_cur_r;
    level_rest_nxt = level_rest_r;
    out_valid_nxt  = out_valid_r & out_stall;
    out_level_nxt  = out_level_r;
    fifo_pop       = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    ram_raddr      = fifo_cmd.addr;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty) begin
          unique case (fifo_cmd.kind)
            CK_WRITE: begin
              fifo_pop       = 1'b1;
              addr_nxt       = fifo_cmd.addr;
              count_nxt      = fifo_cmd.last;
              whole_nxt      = fifo_cmd.whole;
              level_cur_nxt  = fifo_cmd.level_first;
              level_rest_nxt = fifo_cmd.level_rest;
              state_nxt      = ST_WRITE;
            end
            CK_READ: begin
              if (out_free) begin
                fifo_pop  = 1'b1;
                ram_re    = 1'b1;
                state_nxt = ST_READ;
              end
            end
            CK_READ_ZERO: begin
              if (out_free) begin
                fifo_pop      = 1'b1;
                out_valid_nxt = 1'b1;
                out_level_nxt = '0;
              end
            end
            default: begin
              fifo_pop = 1'b1;
            end
          endcase
        end
      end
      ST_WRITE: begin
        ram_we = 1'b1;
        if (count_r == '0) begin
          state_nxt = ST_IDLE;
          clear_nxt = 1'b0;
        end else begin
          count_nxt     = count_r - ADDR_W'(1);
          addr_nxt      = whole_r ? addr_r + ADDR_W'(1) : addr_ring_inc;
          level_cur_nxt = level_rest_r;
        end
      end
      ST_READ: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_level_nxt = ram_rdata;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign ram_waddr = addr_r;
  assign ram_wdata = level_cur_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_WRITE;
      clear_r      <= 1'b1;
      addr_r       <= '0;
      count_r      <= ADDR_W'(MEM_DEPTH - 1);
      whole_r      <= 1'b1;
      level_cur_r  <= '0;
      level_rest_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clear_r      <= clear_nxt;
      addr_r       <= addr_nxt;
      count_r      <= count_nxt;
      whole_r      <= whole_nxt;
      level_cur_r  <= level_cur_nxt;
      level_rest_r <= level_rest_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_level_r <= out_level_nxt;
  end

  assign clear_busy     = clear_r;
  assign out_valid      = out_valid_r;
  assign out_read_level = out_level_r;

endmodule

FILE: design/led_ring_frame_buffer_core.sv
// Top level of the LED ring frame buffer: front end, command queue, back end and level memory.
//
//   Channel  Ports                                  Direction  Word
//   in       in_valid/in_stall + seven field ports  input      one command
//   out      out_valid/out_stall + out_read_level   output     one LED level
//
// Set LED writes one entry in the back end, map byte two, fill ring and range fill up to 64,
// set all NUM_RINGS * 64; a command is first popped from the queue, then the single write
// port of the level memory writes one entry a cycle.
// After reset the back end clears all 256 entries of the memory one entry a cycle,
// and in_stall stays high until that pass ends.
// in_stall also rises while the two-entry command queue is full; a stalled result word is held
// in the output register while the back end keeps running writes.
`timescale 1ns / 1ps
module led_ring_frame_buffer_core import lrfb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [OP_W-1:0]       in_operation,
  input  logic [RING_W-1:0]     in_ring,
  input  logic [POS_W-1:0]      in_position,
  input  logic [POS_W-1:0]      in_end_position,
  input  logic [LEVEL_W-1:0]    in_level,
  input  logic [MAP_IDX_W-1:0]  in_map_index,
  input  logic [MAP_BYTE_W-1:0] in_map_byte,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [LEVEL_W-1:0]    out_read_level
);

  logic               fifo_push;
  cmd_t               push_cmd;
  logic               fifo_full;
  logic               fifo_pop;
  cmd_t               pop_cmd;
  logic               fifo_empty;
  logic               clear_busy;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [LEVEL_W-1:0] ram_wdata;
  logic               ram_re;
  logic [ADDR_W-1:0]  ram_raddr;
  logic [LEVEL_W-1:0] ram_rdata;

  lrfb_front u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_operation    (in_operation),
    .in_ring         (in_ring),
    .in_position     (in_position),
    .in_end_position (in_end_position),
    .in_level        (in_level),
    .in_map_index    (in_map_index),
    .in_map_byte     (in_map_byte),
    .fifo_full       (fifo_full),
    .clear_busy      (clear_busy),
    .fifo_push       (fifo_push),
    .fifo_cmd        (push_cmd)
  );

  lrfb_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (fifo_push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (fifo_pop),
    .pop_cmd  (pop_cmd),
    .empty    (fifo_empty)
  );

  lrfb_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_empty     (fifo_empty),
    .fifo_cmd       (pop_cmd),
    .fifo_pop       (fifo_pop),
    .clear_busy     (clear_busy),
    .ram_we         (ram_we),
    .ram_waddr      (ram_waddr),
    .ram_wdata      (ram_wdata),
    .ram_re         (ram_re),
    .ram_raddr      (ram_raddr),
    .ram_rdata      (ram_rdata),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_read_level (out_read_level)
  );

  lrfb_ram #(
    .WIDTH (LEVEL_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr   (ram_raddr),
    .rdata_r (ram_rdata)
  );

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_full |-> !fifo_push)
    else $error("Command queue written while full.");

  a_no_read_during_write: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re)
    else $error("Level memory read and written in the same cycle.");

  a_clear_only_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$rose(clear_busy))
    else $error("Clearing pass restarted outside reset.");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    fifo_empty |-> !fifo_pop)
    else $error("Command queue read while empty.");

endmodule
